// ===== design/circle_rect_collision_push_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circle/rectangle push unit
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RECT_COLLISION_PUSH_UNIT_MACROS_SVH
`define CIRCLE_RECT_COLLISION_PUSH_UNIT_MACROS_SVH

// same-cycle implication
`define CRC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/crc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc_pkg
// Shared types for the circle/rectangle push pipeline cells.
// ----------------------------------------------------------------------------
package crc_pkg;

   // control carried by every pipeline cell
   typedef struct packed {
      logic vld;   // request present in this cell
      logic live;  // request still a collision candidate
   } ctl_type;

endpackage

// ===== design/crc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// crc_sqrt_cell
// One digit of a restoring square root: consumes two radicand bits, produces
// one root bit, and hands the request to the next cell.
// ----------------------------------------------------------------------------
module crc_sqrt_cell #(
   parameter int N  = 24,
   parameter int SW = 144
) (
   input  logic              clock,
   input  logic              reset,
   input  crc_pkg::ctl_type  ctl_i,
   input  logic [2*N-1:0]    rad_i,
   input  logic [N+1:0]      rem_i,
   input  logic [N-1:0]      root_i,
   input  logic [SW-1:0]     side_i,
   output crc_pkg::ctl_type  ctl_o,
   output logic [2*N-1:0]    rad_o,
   output logic [N+1:0]      rem_o,
   output logic [N-1:0]      root_o,
   output logic [SW-1:0]     side_o
);

   crc_pkg::ctl_type ctl_ff;
   logic [2*N-1:0]   rad_ff, rad_in;
   logic [N+1:0]     rem_ff, rem_in;
   logic [N-1:0]     root_ff, root_in;
   logic [SW-1:0]    side_ff;
   logic [N+3:0]     rem_sh, trial, diff;
   logic             ge;

   // try to subtract the trial divisor from the shifted remainder
   always_comb begin
      rem_sh  = {rem_i, rad_i[2*N-1:2*N-2]};
      trial   = {2'b00, root_i, 2'b01};
      ge      = (rem_sh >= trial);
      diff    = rem_sh - trial;
      rem_in  = ge ? diff[N+1:0] : rem_sh[N+1:0];
      root_in = {root_i[N-2:0], ge};
      rad_in  = {rad_i[2*N-3:0], 2'b00};
   end

   // advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= side_i;
   end

   assign ctl_o  = ctl_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign side_o = side_ff;

endmodule

// ===== design/crc_div_cell.sv =====
// ----------------------------------------------------------------------------
// crc_div_cell
// One step of a two-lane restoring divider: shifts in one dividend bit per
// lane, produces one quotient bit per lane, and hands the request on.
// ----------------------------------------------------------------------------
module crc_div_cell #(
   parameter int N  = 24,
   parameter int DW = 46,
   parameter int SW = 99
) (
   input  logic                  clock,
   input  logic                  reset,
   input  crc_pkg::ctl_type      ctl_i,
   input  logic [1:0][DW-1:0]    num_i,
   input  logic [1:0][N-1:0]     rem_i,
   input  logic [1:0][N-1:0]     quo_i,
   input  logic [N-1:0]          den_i,
   input  logic [SW-1:0]         side_i,
   output crc_pkg::ctl_type      ctl_o,
   output logic [1:0][DW-1:0]    num_o,
   output logic [1:0][N-1:0]     rem_o,
   output logic [1:0][N-1:0]     quo_o,
   output logic [N-1:0]          den_o,
   output logic [SW-1:0]         side_o
);

   crc_pkg::ctl_type      ctl_ff;
   logic [1:0][DW-1:0]    num_ff, num_in;
   logic [1:0][N-1:0]     rem_ff, rem_in;
   logic [1:0][N-1:0]     quo_ff, quo_in;
   logic [N-1:0]          den_ff;
   logic [SW-1:0]         side_ff;
   logic [1:0][N:0]       rem_sh, diff;
   logic [1:0]            ge;

   // subtract the divisor where it fits, per lane
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem_sh[l] = {rem_i[l], num_i[l][DW-1]};
         ge[l]     = (rem_sh[l] >= {1'b0, den_i});
         diff[l]   = rem_sh[l] - {1'b0, den_i};
         rem_in[l] = ge[l] ? diff[l][N-1:0] : rem_sh[l][N-1:0];
         quo_in[l] = {quo_i[l][N-2:0], ge[l]};
         num_in[l] = {num_i[l][DW-2:0], 1'b0};
      end
   end

   // advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_i;
      side_ff <= side_i;
   end

   assign ctl_o  = ctl_ff;
   assign num_o  = num_ff;
   assign rem_o  = rem_ff;
   assign quo_o  = quo_ff;
   assign den_o  = den_ff;
   assign side_o = side_ff;

endmodule

// ===== design/circle_rect_collision_push_unit.sv =====
// ----------------------------------------------------------------------------
// circle_rect_collision_push_unit
// Circle versus axis-aligned rectangle test with push-out of the centre.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   req_* fields                  taken when start & !busy
//  result    rsp_new_x/new_y/hit           one-cycle strobe rsp_valid
//
// One request per cycle enters while busy is low; each passes stages 0-4, the
// square-root row (COORD_BITS cells), stages 5-6, the divider row
// (2*COORD_BITS-2 cells), one bit per cell, and the output register.
// Reset is synchronous; busy is a registered copy of reset.
// The result side cannot stall: results are strobed for one cycle.
// ----------------------------------------------------------------------------
`include "circle_rect_collision_push_unit_macros.svh"

module circle_rect_collision_push_unit #(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_circle_x,
   input  logic signed [COORD_BITS-1:0] req_circle_y,
   input  logic signed [COORD_BITS-1:0] req_circle_radius,
   input  logic signed [COORD_BITS-1:0] req_box_x,
   input  logic signed [COORD_BITS-1:0] req_box_y,
   input  logic signed [COORD_BITS-1:0] req_box_width,
   input  logic signed [COORD_BITS-1:0] req_box_height,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_new_x,
   output logic signed [COORD_BITS-1:0] rsp_new_y,
   output logic                         rsp_hit
);

   localparam int N        = COORD_BITS;
   localparam int DW       = 2 * N - 2;
   localparam int SQ_SW    = 6 * N;
   localparam int DV_SW    = 4 * N + 3;
   localparam int NEAR_LIM = (2 ** FRAC_BITS + 999) / 1000;
   localparam int LAT      = 3 * N + 6;

   // saturate a wide signed value into the coordinate range
   function automatic logic [N-1:0] sat(input logic signed [N+1:0] v);
      logic signed [N+1:0] hi;
      logic signed [N+1:0] lo;
      hi = {3'b000, {(N-1){1'b1}}};
      lo = {3'b111, {(N-1){1'b0}}};
      if (v > hi)      sat = hi[N-1:0];
      else if (v < lo) sat = lo[N-1:0];
      else             sat = v[N-1:0];
   endfunction

   logic busy_ff;
   logic acc;

   // stage 0: edges and degenerate check
   logic                s0_vld_ff, s0_bad_ff;
   logic signed [N-1:0] s0_cx_ff, s0_cy_ff, s0_r_ff, s0_bx_ff, s0_by_ff;
   logic signed [N:0]   s0_ex_ff, s0_ey_ff;
   // stage 1: clamped deltas
   logic                s1_vld_ff, s1_bad_ff;
   logic signed [N-1:0] s1_cx_ff, s1_cy_ff, s1_r_ff, s1_by_ff;
   logic signed [N+1:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic signed [N:0]   cx_e, cy_e, bx_e, by_e, lox, loy, px, py;
   // stage 2: magnitudes and early reject
   crc_pkg::ctl_type    s2_ctl_ff, s2_ctl_in;
   logic [N-1:0]        s2_cx_ff, s2_cy_ff, s2_r_ff, s2_by_ff;
   logic                s2_sx_ff, s2_sy_ff;
   logic [N-2:0]        s2_ax_ff, s2_ay_ff;
   logic [N+1:0]        adx, ady, rz;
   // stage 3: squares
   crc_pkg::ctl_type    s3_ctl_ff;
   logic [SQ_SW-1:0]    s3_side_ff;
   logic [2*N-3:0]      s3_qx_ff, s3_qy_ff;
   // stage 4: radicand
   crc_pkg::ctl_type    s4_ctl_ff;
   logic [SQ_SW-1:0]    s4_side_ff;
   logic [2*N-1:0]      s4_rad_ff;
   // square-root row
   crc_pkg::ctl_type    sq_ctl  [0:N];
   logic [2*N-1:0]      sq_rad  [0:N];
   logic [N+1:0]        sq_rem  [0:N];
   logic [N-1:0]        sq_root [0:N];
   logic [SQ_SW-1:0]    sq_side [0:N];
   // stage 5: hit decision and gap
   logic [N-1:0]        t_cx, t_cy, t_r, t_by, root_dist;
   logic                t_sx, t_sy;
   logic [N-2:0]        t_ax, t_ay;
   crc_pkg::ctl_type    s5_ctl_ff, s5_ctl_in;
   logic [DV_SW-1:0]    s5_side_ff;
   logic [N-2:0]        s5_ax_ff, s5_ay_ff, s5_gap_ff;
   logic [N-1:0]        s5_dist_ff;
   logic [N-1:0]        gap_full;
   // stage 6: push numerators
   crc_pkg::ctl_type    s6_ctl_ff;
   logic [DV_SW-1:0]    s6_side_ff;
   logic [1:0][DW-1:0]  s6_num_ff;
   logic [N-1:0]        s6_den_ff;
   // divider row
   crc_pkg::ctl_type    dv_ctl  [0:DW];
   logic [1:0][DW-1:0]  dv_num  [0:DW];
   logic [1:0][N-1:0]   dv_rem  [0:DW];
   logic [1:0][N-1:0]   dv_quo  [0:DW];
   logic [N-1:0]        dv_den  [0:DW];
   logic [DV_SW-1:0]    dv_side [0:DW];
   // output stage
   logic signed [N-1:0] o_cx, o_cy, o_r, o_by;
   logic                o_sx, o_sy, o_near;
   logic signed [N+1:0] qx_e, qy_e, cx_w, cy_w, top_w;
   logic                rsp_valid_ff, rsp_hit_ff;
   logic [N-1:0]        new_x_ff, new_y_ff, new_x_in, new_y_in;

   assign acc  = start && !busy_ff;
   assign busy = busy_ff;

   // hold busy during reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      s0_bad_ff <= (req_circle_radius <= 0) || (req_box_width <= 0) || (req_box_height <= 0);
      s0_cx_ff  <= req_circle_x;
      s0_cy_ff  <= req_circle_y;
      s0_r_ff   <= req_circle_radius;
      s0_bx_ff  <= req_box_x;
      s0_by_ff  <= req_box_y;
      s0_ex_ff  <= {req_box_x[N-1], req_box_x} + {req_box_width[N-1], req_box_width};
      s0_ey_ff  <= {req_box_y[N-1], req_box_y} + {req_box_height[N-1], req_box_height};
   end

   // stage 1: clamp centre into the rectangle
   always_comb begin
      cx_e     = {s0_cx_ff[N-1], s0_cx_ff};
      cy_e     = {s0_cy_ff[N-1], s0_cy_ff};
      bx_e     = {s0_bx_ff[N-1], s0_bx_ff};
      by_e     = {s0_by_ff[N-1], s0_by_ff};
      lox      = (cx_e < s0_ex_ff) ? cx_e : s0_ex_ff;
      loy      = (cy_e < s0_ey_ff) ? cy_e : s0_ey_ff;
      px       = (lox < bx_e) ? bx_e : lox;
      py       = (loy < by_e) ? by_e : loy;
      s1_dx_in = {cx_e[N], cx_e} - {px[N], px};
      s1_dy_in = {cy_e[N], cy_e} - {py[N], py};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_bad_ff <= s0_bad_ff;
      s1_cx_ff  <= s0_cx_ff;
      s1_cy_ff  <= s0_cy_ff;
      s1_r_ff   <= s0_r_ff;
      s1_by_ff  <= s0_by_ff;
      s1_dx_ff  <= s1_dx_in;
      s1_dy_ff  <= s1_dy_in;
   end

   // stage 2: clear live for degenerate requests and those whose delta already reaches the radius
   always_comb begin
      adx = s1_dx_ff[N+1] ? (N+2)'(-s1_dx_ff) : s1_dx_ff;
      ady = s1_dy_ff[N+1] ? (N+2)'(-s1_dy_ff) : s1_dy_ff;
      rz  = {2'b00, s1_r_ff};
      s2_ctl_in.vld  = s1_vld_ff;
      s2_ctl_in.live = s1_vld_ff && !s1_bad_ff && (adx < rz) && (ady < rz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_cx_ff <= s1_cx_ff;
      s2_cy_ff <= s1_cy_ff;
      s2_r_ff  <= s1_r_ff;
      s2_by_ff <= s1_by_ff;
      s2_sx_ff <= s1_dx_ff[N+1];
      s2_sy_ff <= s1_dy_ff[N+1];
      s2_ax_ff <= adx[N-2:0];
      s2_ay_ff <= ady[N-2:0];
   end

   // stage 3: squares
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_qx_ff   <= s2_ax_ff * s2_ax_ff;
      s3_qy_ff   <= s2_ay_ff * s2_ay_ff;
      s3_side_ff <= {s2_cx_ff, s2_cy_ff, s2_r_ff, s2_by_ff,
                     s2_sx_ff, s2_sy_ff, s2_ax_ff, s2_ay_ff};
   end

   // stage 4: sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else begin
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_rad_ff  <= {2'b00, s3_qx_ff} + {2'b00, s3_qy_ff};
      s4_side_ff <= s3_side_ff;
   end

   // square-root row, one root bit per cell
   assign sq_ctl[0]  = s4_ctl_ff;
   assign sq_rad[0]  = s4_rad_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = s4_side_ff;

   for (genvar i = 0; i < N; i++) begin : g_sqrt
      crc_sqrt_cell #(.N(N), .SW(SQ_SW)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (sq_ctl[i]),
         .rad_i  (sq_rad[i]),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .side_i (sq_side[i]),
         .ctl_o  (sq_ctl[i+1]),
         .rad_o  (sq_rad[i+1]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1]),
         .side_o (sq_side[i+1])
      );
   end

   // stage 5: compare distance with radius
   always_comb begin
      {t_cx, t_cy, t_r, t_by, t_sx, t_sy, t_ax, t_ay} = sq_side[N];
      root_dist      = sq_root[N];
      gap_full       = t_r - root_dist;
      s5_ctl_in.vld  = sq_ctl[N].vld;
      s5_ctl_in.live = sq_ctl[N].live && (root_dist < t_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff <= '0;
      end else begin
         s5_ctl_ff <= s5_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s5_ax_ff   <= t_ax;
      s5_ay_ff   <= t_ay;
      s5_gap_ff  <= gap_full[N-2:0];
      s5_dist_ff <= root_dist;
      s5_side_ff <= {t_cx, t_cy, t_r, t_by, t_sx, t_sy, (root_dist < N'(NEAR_LIM))};
   end

   // stage 6: push numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
      end else begin
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_num_ff[0] <= s5_ax_ff * s5_gap_ff;
      s6_num_ff[1] <= s5_ay_ff * s5_gap_ff;
      s6_den_ff    <= s5_dist_ff;
      s6_side_ff   <= s5_side_ff;
   end

   // divider row, one quotient bit per cell and lane
   assign dv_ctl[0]  = s6_ctl_ff;
   assign dv_num[0]  = s6_num_ff;
   assign dv_rem[0]  = '0;
   assign dv_quo[0]  = '0;
   assign dv_den[0]  = s6_den_ff;
   assign dv_side[0] = s6_side_ff;

   for (genvar j = 0; j < DW; j++) begin : g_div
      crc_div_cell #(.N(N), .DW(DW), .SW(DV_SW)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (dv_ctl[j]),
         .num_i  (dv_num[j]),
         .rem_i  (dv_rem[j]),
         .quo_i  (dv_quo[j]),
         .den_i  (dv_den[j]),
         .side_i (dv_side[j]),
         .ctl_o  (dv_ctl[j+1]),
         .num_o  (dv_num[j+1]),
         .rem_o  (dv_rem[j+1]),
         .quo_o  (dv_quo[j+1]),
         .den_o  (dv_den[j+1]),
         .side_o (dv_side[j+1])
      );
   end

   // output stage: keep the centre when not live, else apply push and saturate
   always_comb begin
      {o_cx, o_cy, o_r, o_by, o_sx, o_sy, o_near} = dv_side[DW];
      qx_e  = {2'b00, dv_quo[DW][0]};
      qy_e  = {2'b00, dv_quo[DW][1]};
      cx_w  = {{2{o_cx[N-1]}}, o_cx};
      cy_w  = {{2{o_cy[N-1]}}, o_cy};
      top_w = {{2{o_by[N-1]}}, o_by} - {{2{o_r[N-1]}}, o_r};
      if (!dv_ctl[DW].live) begin
         new_x_in = o_cx;
         new_y_in = o_cy;
      end else if (o_near) begin
         new_x_in = o_cx;
         new_y_in = sat(top_w);
      end else begin
         new_x_in = sat(o_sx ? cx_w - qx_e : cx_w + qx_e);
         new_y_in = sat(o_sy ? cy_w - qy_e : cy_w + qy_e);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ctl[DW].vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= dv_ctl[DW].live;
      new_x_ff   <= new_x_in;
      new_y_ff   <= new_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff && rsp_valid_ff;
   assign rsp_new_x = new_x_ff;
   assign rsp_new_y = new_y_ff;

   // checks
   `CRC_ASSERT_NOW(a_latency, $past(acc, LAT), rsp_valid, "result strobe off schedule")
   `CRC_ASSERT_NEXT(a_bad_no_live, s1_vld_ff && s1_bad_ff, !s2_ctl_ff.live, "degenerate request live")
   `CRC_ASSERT_NOW(a_live_vld, s5_ctl_ff.live, s5_ctl_ff.vld, "live flag without request")

endmodule
